// ----- design/square_wave_fourier_partial_sum_defines.svh -----
// Assertion macros for the square-wave partial-sum block.
// Used by square_wave_fourier_partial_sum.sv; expects clk and rst in scope.
`ifndef SQUARE_WAVE_FOURIER_PARTIAL_SUM_DEFINES_SVH
`define SQUARE_WAVE_FOURIER_PARTIAL_SUM_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define SQWFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked in the following cycle
`define SQWFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/sqwfs_pkg.sv -----
// Shared types and fixed-point constants for the square-wave partial-sum block.
// No dependencies; imported by every module of the block.
package sqwfs_pkg;

  // Fixed-point layout: Q30 fractions, 31-bit multiplier operands
  localparam int Q_FRAC = 30;
  localparam int OPW    = 31;
  localparam int TURN_W = 32;
  localparam int ACC_W  = 36;
  localparam int CFG_W  = 8;
  localparam int OUT_W  = 20;

  localparam logic [OPW-1:0] Q30_ONE = 31'h4000_0000;

  // 4/pi in Q30, numerator of the harmonic coefficients
  localparam logic [31:0] FOUR_OVER_PI_Q30 = 32'd1367130551;

  // Taylor coefficients of sin(pi/2 * u), Q30
  localparam logic [OPW-1:0] SIN_C1 = 31'd1686629713;
  localparam logic [OPW-1:0] SIN_C3 = 31'd693598670;
  localparam logic [OPW-1:0] SIN_C5 = 31'd85569306;
  localparam logic [OPW-1:0] SIN_C7 = 31'd5026995;
  localparam logic [OPW-1:0] SIN_C9 = 31'd172272;

  // Output saturation bounds
  localparam logic [OUT_W-1:0] OUT_MAX_C = 20'h7FFFF;
  localparam logic [OUT_W-1:0] OUT_MIN_C = 20'h80000;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ANGLE  = 6'b000010,
    ST_ISSUE  = 6'b000100,
    ST_UPDATE = 6'b001000,
    ST_ROUND  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  // Multiplier passes within one harmonic
  typedef enum logic [2:0] {
    STEP_U2   = 3'd0,
    STEP_C7   = 3'd1,
    STEP_C5   = 3'd2,
    STEP_C3   = 3'd3,
    STEP_C1   = 3'd4,
    STEP_SIN  = 3'd5,
    STEP_TERM = 3'd6
  } step_t;

endpackage

// ----- design/sqwfs_coef_rom.sv -----
// Coefficient table 4/(k*pi) in Q30 for odd harmonics k = 2*index+1.
// Depends on sqwfs_pkg; registered read.
module sqwfs_coef_rom
  import sqwfs_pkg::*;
#(
  parameter int NCOEF = 64,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] addr,
  output logic [OPW-1:0]   coef
);

  logic [OPW-1:0] coef_tab [NCOEF];

  // Entries worked out at elaboration: floor((4/pi*2^30 + k/2) / k)
  for (genvar g = 0; g < NCOEF; g++) begin : g_coef
    localparam longint unsigned KV = 2 * g + 1;
    localparam longint unsigned CV = (longint'(FOUR_OVER_PI_Q30) + g) / KV;
    assign coef_tab[g] = OPW'(CV);
  end

  // Registered table read
  always_ff @(posedge clk) begin
    coef <= coef_tab[addr];
  end

endmodule

// ----- design/sqwfs_mul.sv -----
// Shared Q30 multiplier: registered (a * b) >> 30.
// Depends on sqwfs_pkg; operands are known to keep the product below 2^61.
module sqwfs_mul
  import sqwfs_pkg::*;
(
  input  logic           clk,
  input  logic [OPW-1:0] a,
  input  logic [OPW-1:0] b,
  output logic [OPW-1:0] q
);

  logic [2*OPW-2:0] prod;

  assign prod = (2*OPW-1)'(a) * (2*OPW-1)'(b);

  always_ff @(posedge clk) begin
    q <= prod[2*OPW-2:Q_FRAC];
  end

endmodule

// ----- design/square_wave_fourier_partial_sum.sv -----
// Square-wave partial Fourier sum: top level with handshakes, sequencer, datapath.
// Depends on sqwfs_pkg, sqwfs_coef_rom, sqwfs_mul and the assertion macro header.
//
// Usage:
//   Input channel: phase (fraction of a turn) with in_valid / in_stall; a transfer
//   happens when in_valid is high and in_stall low. in_stall is high while an item
//   is being summed.
//   Output channel: series_value (signed, OUT_FRAC_BITS fraction bits) with
//   out_valid / out_stall, held in an output register.
//   Config channel: num_terms write with cfg_valid / cfg_ready (always ready);
//   write only while idle. Values above MAX_TERMS act as MAX_TERMS.
//   Sequence: each odd harmonic takes an angle step, then seven multiply passes
//   (issue, then update) on the one shared 31x31 multiplier. A round state and a
//   done state follow the last harmonic; with N = 0 no harmonic is run. The next
//   item is taken in the cycle after the result is loaded into the output register.
//   Receiver stall: a finished result waits in the sequencer until the output
//   register is free; one result may sit in the output register meanwhile.
//   Reset (rst, synchronous): sequencer idle, output empty, num_terms = 1.
`include "square_wave_fourier_partial_sum_defines.svh"

module square_wave_fourier_partial_sum
  import sqwfs_pkg::*;
#(
  parameter int MAX_TERMS     = 128,
  parameter int PHASE_BITS    = 16,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PHASE_BITS-1:0] phase,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_W-1:0]      series_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      num_terms
);

  localparam int NCOEF     = (MAX_TERMS + 1) / 2;
  localparam int IDX_W     = (NCOEF > 1) ? $clog2(NCOEF) : 1;
  localparam int CNT_W     = $clog2(NCOEF + 1);
  localparam int LIM_W     = ($clog2(MAX_TERMS + 1) > CFG_W) ? $clog2(MAX_TERMS + 1) : CFG_W;
  localparam int RND_SHIFT = Q_FRAC - OUT_FRAC_BITS;
  localparam logic [ACC_W-1:0] RND_HALF = (ACC_W'(1) << RND_SHIFT) >> 1;

  state_t                  state;
  step_t                   step;
  logic [CFG_W-1:0]        term_limit;
  logic [PHASE_BITS-1:0]   ang;
  logic [PHASE_BITS-1:0]   phase2;
  logic [CNT_W-1:0]        g_cnt;
  logic [CNT_W-1:0]        n_odd;
  logic [OPW-1:0]          u_q;
  logic [OPW-1:0]          u2_q;
  logic [OPW-1:0]          p_q;
  logic                    term_neg;
  logic [ACC_W-1:0]        acc;
  logic [ACC_W-1:0]        rnd_mag;
  logic                    rnd_neg;

  logic                    in_xfer;
  logic                    out_xfer;
  logic                    out_free;
  logic [LIM_W-1:0]        n_lim;
  logic [LIM_W:0]          n_sum;
  logic [CNT_W-1:0]        n_odd_next;
  logic [CNT_W-1:0]        g_next;
  logic [TURN_W-1:0]       turn;
  logic [OPW-1:0]          u_next;
  logic [OPW-1:0]          mul_a;
  logic [OPW-1:0]          mul_b;
  logic [OPW-1:0]          mul_q;
  logic [OPW-1:0]          coef;
  logic [ACC_W-1:0]        acc_mag;
  logic [OUT_W-1:0]        sat_val;

  // Handshakes
  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      term_limit <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      term_limit <= num_terms;
    end
  end

  // Odd-harmonic count: ceil(min(N, MAX_TERMS) / 2)
  assign n_lim = (LIM_W'(term_limit) > LIM_W'(MAX_TERMS)) ? LIM_W'(MAX_TERMS)
                                                           : LIM_W'(term_limit);
  assign n_sum      = (LIM_W+1)'(n_lim) + (LIM_W+1)'(1);
  assign n_odd_next = CNT_W'(n_sum >> 1);
  assign g_next     = CNT_W'(g_cnt + CNT_W'(1));

  // Quarter-wave folding of k*x
  assign turn   = TURN_W'(ang) << (TURN_W - PHASE_BITS);
  assign u_next = turn[Q_FRAC] ? (Q30_ONE - OPW'(turn[Q_FRAC-1:0]))
                               : OPW'(turn[Q_FRAC-1:0]);

  // Multiplier operand select per pass
  always_comb begin
    case (step)
      STEP_U2: begin
        mul_a = u_q;
        mul_b = u_q;
      end
      STEP_C7: begin
        mul_a = u2_q;
        mul_b = SIN_C9;
      end
      STEP_C5, STEP_C3, STEP_C1: begin
        mul_a = u2_q;
        mul_b = p_q;
      end
      STEP_SIN: begin
        mul_a = u_q;
        mul_b = p_q;
      end
      STEP_TERM: begin
        mul_a = coef;
        mul_b = p_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  sqwfs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .q   (mul_q)
  );

  sqwfs_coef_rom #(
    .NCOEF (NCOEF),
    .IDX_W (IDX_W)
  ) u_coef_rom (
    .clk  (clk),
    .addr (g_cnt[IDX_W-1:0]),
    .coef (coef)
  );

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_U2;
      g_cnt <= '0;
      n_odd <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            g_cnt <= '0;
            n_odd <= n_odd_next;
            state <= (n_odd_next == '0) ? ST_ROUND : ST_ANGLE;
          end
        end
        ST_ANGLE: begin
          step  <= STEP_U2;
          state <= ST_ISSUE;
        end
        ST_ISSUE: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          case (step)
            STEP_U2:   step <= STEP_C7;
            STEP_C7:   step <= STEP_C5;
            STEP_C5:   step <= STEP_C3;
            STEP_C3:   step <= STEP_C1;
            STEP_C1:   step <= STEP_SIN;
            STEP_SIN:  step <= STEP_TERM;
            default:   step <= STEP_U2;
          endcase
          if (step == STEP_TERM) begin
            g_cnt <= g_next;
            state <= (g_next == n_odd) ? ST_ROUND : ST_ANGLE;
          end else begin
            state <= ST_ISSUE;
          end
        end
        ST_ROUND: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_xfer) begin
      ang    <= phase;
      phase2 <= {phase[PHASE_BITS-2:0], 1'b0};
      acc    <= '0;
    end
    if (state == ST_ANGLE) begin
      u_q      <= u_next;
      term_neg <= turn[TURN_W-1];
    end
    if (state == ST_UPDATE) begin
      case (step)
        STEP_U2:   u2_q <= mul_q;
        STEP_C7:   p_q  <= SIN_C7 - mul_q;
        STEP_C5:   p_q  <= SIN_C5 - mul_q;
        STEP_C3:   p_q  <= SIN_C3 - mul_q;
        STEP_C1:   p_q  <= SIN_C1 - mul_q;
        STEP_SIN:  p_q  <= (mul_q > Q30_ONE) ? Q30_ONE : mul_q;
        STEP_TERM: begin
          acc <= term_neg ? (acc - ACC_W'(mul_q)) : (acc + ACC_W'(mul_q));
          ang <= ang + phase2;
        end
        default: ;
      endcase
    end
    if (state == ST_ROUND) begin
      rnd_mag <= (acc_mag + RND_HALF) >> RND_SHIFT;
      rnd_neg <= acc[ACC_W-1];
    end
  end

  // Round half away from zero, then saturate
  assign acc_mag = acc[ACC_W-1] ? (ACC_W'(0) - acc) : acc;

  always_comb begin
    if (rnd_neg) begin
      sat_val = (rnd_mag > ACC_W'(OUT_MIN_C)) ? OUT_MIN_C : OUT_W'(ACC_W'(0) - rnd_mag);
    end else begin
      sat_val = (rnd_mag > ACC_W'(OUT_MAX_C)) ? OUT_MAX_C : OUT_W'(rnd_mag);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      series_value <= sat_val;
    end
  end

  // Checks
  `SQWFS_ASSERT(a_term_in_range, (state == ST_ANGLE || state == ST_ISSUE || state == ST_UPDATE) |-> (g_cnt < n_odd), "harmonic index past term count")
  `SQWFS_ASSERT(a_acc_held, (state == ST_DONE) |-> $stable(acc), "accumulator changed after last term")
  `SQWFS_ASSERT_NEXT(a_wait_full_out, (state == ST_DONE && out_valid && out_stall), (state == ST_DONE), "result left while output register full")
  `SQWFS_ASSERT(a_sine_capped, (state == ST_ISSUE && step == STEP_TERM) |-> (p_q <= Q30_ONE), "sine magnitude above one")

endmodule
